/* hdl/gsfp_pkg.sv */
// Shared types and constants for the gas sensor frame parser.
package gsfp_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned READING_W    = 16;
    localparam int unsigned TICK_W       = 20;
    localparam int unsigned COUNT_W      = 4;
    localparam int unsigned READING_NUM  = 6;
    localparam int unsigned READ_IDX_W   = 3;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 20;
    localparam int unsigned OUT_DATA_W   = 3 * READING_W;

    localparam logic [COUNT_W-1:0] FRAME_SUMMED_BYTES = COUNT_W'(8);
    localparam logic [TICK_W-1:0]  TICK_MAX           = {TICK_W{1'b1}};

    localparam logic [BYTE_W-1:0] ADDRESS_HIGH_RST = 8'd44;
    localparam logic [BYTE_W-1:0] ADDRESS_LOW_RST  = 8'd228;
    localparam logic [TICK_W-1:0] WARMUP_TICKS_RST = 20'd180000;

    typedef enum logic
    {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_ADDRESS_HIGH = 2'd0,
        CFG_ADDRESS_LOW  = 2'd1,
        CFG_WARMUP_TICKS = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] address_high;
        logic [BYTE_W-1:0] address_low;
        logic [TICK_W-1:0] warmup_ticks;
    } gsfp_cfg_t;

    typedef struct packed
    {
        logic                 status;
        logic [READING_W-1:0] tvoc_raw;
        logic [READING_W-1:0] formaldehyde_raw;
        logic [READING_W-1:0] co2_raw;
    } gsfp_result_t;

endpackage

/* hdl/gsfp_parser.sv */
// Frame collection state, checksum check and tick counter for one item per step.
module gsfp_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  gsfp_pkg::opcode_t                   opcode,
    input  logic [gsfp_pkg::BYTE_W-1:0]         rx_byte,
    input  gsfp_pkg::gsfp_cfg_t                 cfg,
    output logic                                emit,
    output gsfp_pkg::gsfp_result_t              result
);
    import gsfp_pkg::*;

    logic                  receiving_reg, receiving_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [BYTE_W-1:0]     sum_reg, sum_next;
    logic [TICK_W-1:0]     elapsed_reg, elapsed_next;
    logic [BYTE_W-1:0]     second_reg;
    logic [BYTE_W-1:0]     reading_reg [READING_NUM];
    logic                  second_wr;
    logic                  reading_wr;
    logic [READ_IDX_W-1:0] reading_idx;

    assign reading_idx = READ_IDX_W'(count_reg - COUNT_W'(2));

    always_comb
    begin
        receiving_next = receiving_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        elapsed_next   = elapsed_reg;
        second_wr      = 1'b0;
        reading_wr     = 1'b0;
        emit           = 1'b0;
        if (step)
        begin
            if (opcode == OP_TICK)
            begin
                if (elapsed_reg != TICK_MAX)
                begin
                    elapsed_next = elapsed_reg + TICK_W'(1);
                end
            end
            else if (!receiving_reg)
            begin
                if (rx_byte == cfg.address_high)
                begin
                    receiving_next = 1'b1;
                    count_next     = COUNT_W'(1);
                    sum_next       = rx_byte;
                end
            end
            else if (count_reg < FRAME_SUMMED_BYTES)
            begin
                second_wr  = (count_reg == COUNT_W'(1));
                reading_wr = (count_reg != COUNT_W'(1));
                sum_next   = sum_reg + rx_byte;
                count_next = count_reg + COUNT_W'(1);
            end
            else
            begin
                // checksum byte: frame ends here whether or not it matches
                emit           = (second_reg == cfg.address_low) && (sum_reg == rx_byte);
                receiving_next = 1'b0;
                count_next     = '0;
                sum_next       = '0;
            end
        end
    end

    assign result.status           = (elapsed_reg < cfg.warmup_ticks);
    assign result.tvoc_raw         = {reading_reg[0], reading_reg[1]};
    assign result.formaldehyde_raw = {reading_reg[2], reading_reg[3]};
    assign result.co2_raw          = {reading_reg[4], reading_reg[5]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            elapsed_reg   <= '0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (second_wr)
        begin
            second_reg <= rx_byte;
        end
        if (reading_wr)
        begin
            reading_reg[reading_idx] <= rx_byte;
        end
    end

endmodule

/* hdl/gas_sensor_frame_parser_core.sv */
// Top level of the gas sensor frame parser: stream ports, config registers, result register.
// The block takes a stream of received serial bytes and millisecond ticks (tuser set) and
// emits one transaction per valid 9-byte frame carrying the TVOC, formaldehyde and CO2
// readings plus a warm-up flag. A frame starts on a byte equal to address_high; it is
// dropped silently when its second byte differs from address_low or its last byte is not
// the 8-bit sum of the first eight. Each item is registered on entry, applied to the frame
// state when the output register is free or being read, and any result lands in an output
// register, so a new item is accepted every cycle while the output side keeps up.
// Configuration writes are always ready and take effect on the next cycle; writes to an
// index past the last register are ignored.
module gas_sensor_frame_parser_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [gsfp_pkg::BYTE_W-1:0]          s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]                           s_axis_tuser,   // [0] opcode
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] tvoc_raw, [31:16] formaldehyde_raw, [47:32] co2_raw
    output logic [gsfp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [0:0]                           m_axis_tuser,   // [0] status
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gsfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gsfp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import gsfp_pkg::*;

    gsfp_cfg_t    cfg_reg;
    logic         in_valid_reg;
    opcode_t      in_op_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic         out_valid_reg;
    gsfp_result_t out_reg;
    logic         proceed;
    logic         emit;
    gsfp_result_t result;

    assign cfg_ready     = 1'b1;
    assign proceed       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_high <= ADDRESS_HIGH_RST;
            cfg_reg.address_low  <= ADDRESS_LOW_RST;
            cfg_reg.warmup_ticks <= WARMUP_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ADDRESS_HIGH: cfg_reg.address_high <= cfg_data[BYTE_W-1:0];
                CFG_ADDRESS_LOW:  cfg_reg.address_low  <= cfg_data[BYTE_W-1:0];
                CFG_WARMUP_TICKS: cfg_reg.warmup_ticks <= cfg_data[TICK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (proceed)
            begin
                out_valid_reg <= emit;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg   <= opcode_t'(s_axis_tuser[0]);
            in_byte_reg <= s_axis_tdata;
        end
        if (proceed && emit)
        begin
            out_reg <= result;
        end
    end

    gsfp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (proceed),
        .opcode  (in_op_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .result  (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {out_reg.co2_raw, out_reg.formaldehyde_raw, out_reg.tvoc_raw};

endmodule
